// ----- rtl/core/vrta_pkg.sv -----
package vrta_pkg;

    // default table geometry
    localparam int NUM_REGIONS_DEF = 512;
    localparam int PAGE_BYTES_DEF  = 4096;

    // request kinds
    localparam logic [1:0] REQ_ALLOC   = 2'd0;
    localparam logic [1:0] REQ_RELEASE = 2'd1;
    localparam logic [1:0] REQ_CHECK   = 2'd2;

    // result status codes
    localparam logic [1:0] ST_DONE      = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_NOT_FOUND = 2'd2;

    // one region table entry
    typedef struct packed {
        logic [31:0] byte_len;
        logic [31:0] start_addr;
    } t_entry;

    // sequencer to head unit
    typedef struct packed {
        logic start;
        logic step;
    } t_head_ctl;

    // head unit to sequencer
    typedef struct packed {
        logic [31:0] res_addr;
        logic [31:0] res_len;
        logic [1:0]  status;
        logic        legit;
        logic        grow;
        logic        shrink;
    } t_head_res;

endpackage

// ----- rtl/core/vrta_cell.sv -----
module vrta_cell #(
    parameter logic [31:0] RST_START = 32'd0,
    parameter logic [31:0] RST_LEN   = 32'd0
) (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_load,
    input  vrta_pkg::t_entry i_d,
    output vrta_pkg::t_entry o_q
);

    vrta_pkg::t_entry r_q;

    // one table slot, takes its neighbor's entry on each ring step
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q.start_addr <= RST_START;
            r_q.byte_len   <= RST_LEN;
        end else if (i_load) begin
            r_q <= i_d;
        end
    end

    assign o_q = r_q;

endmodule

// ----- rtl/core/vrta_head.sv -----
module vrta_head #(
    parameter int NUM_REGIONS = vrta_pkg::NUM_REGIONS_DEF,
    parameter int PAGE_BYTES  = vrta_pkg::PAGE_BYTES_DEF
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  vrta_pkg::t_head_ctl              i_ctl,
    input  logic [$clog2(NUM_REGIONS)-1:0]   i_k,
    input  logic [$clog2(NUM_REGIONS+1)-1:0] i_used,
    input  logic [1:0]                       i_req_type,
    input  logic [31:0]                      i_req_size,
    input  logic [31:0]                      i_req_address,
    input  vrta_pkg::t_entry                 i_head,
    input  vrta_pkg::t_entry                 i_next,
    output vrta_pkg::t_entry                 o_feed,
    output vrta_pkg::t_head_res              o_res
);

    localparam int          CNT_W     = $clog2(NUM_REGIONS+1);
    localparam logic [32:0] PAGE_M1   = 33'(PAGE_BYTES - 1);
    localparam logic [32:0] PAGE_MASK = ~PAGE_M1;
    localparam logic [33:0] ADDR_TOP  = 34'h1_0000_0000;

    logic [1:0]  r_type;
    logic        r_zero;
    logic        r_full;
    logic        r_found;
    logic        r_grow;
    logic        r_legit;
    logic        r_ovf;
    logic [31:0] r_addr;
    logic [32:0] r_len;
    logic [32:0] r_last_end;
    logic [31:0] r_res_addr;
    logic [31:0] r_res_len;

    logic [CNT_W-1:0] w_k_ext;
    logic [CNT_W-1:0] w_k_inc;
    logic             w_in_used;
    logic             w_is_last;
    logic             w_is_free;
    logic [32:0]      w_head_end;
    logic [33:0]      w_new_end;
    logic             w_fits;
    logic             w_alloc_slot;
    logic             w_hit;
    logic             w_del;
    logic             w_in_range;

    // position of the entry now at the ring head
    assign w_k_ext   = CNT_W'(i_k);
    assign w_k_inc   = w_k_ext + CNT_W'(1);
    assign w_in_used = w_k_ext < i_used;
    assign w_is_last = w_k_inc == i_used;
    assign w_is_free = w_k_ext == i_used;

    // region end, exclusive, and end of the region being appended
    assign w_head_end = {1'b0, i_head.start_addr} + {1'b0, i_head.byte_len};
    assign w_new_end  = {1'b0, r_last_end} + {1'b0, r_len};
    assign w_fits     = !r_len[32] && (w_new_end <= ADDR_TOP);

    assign w_alloc_slot = (r_type == vrta_pkg::REQ_ALLOC) && w_is_free && !r_zero && !r_full;
    assign w_hit = (r_type == vrta_pkg::REQ_RELEASE) && !r_found && (i_k != '0) && w_in_used
                   && (i_head.start_addr == r_addr);
    assign w_del = (r_type == vrta_pkg::REQ_RELEASE) && (r_found || w_hit);
    assign w_in_range = w_in_used && (r_addr >= i_head.start_addr)
                        && ({1'b0, r_addr} < w_head_end);

    // entry written back at the ring tail
    always_comb begin
        o_feed = i_head;
        if (w_alloc_slot && w_fits) begin
            o_feed.start_addr = r_last_end[31:0];
            o_feed.byte_len   = r_len[31:0];
        end else if (w_del) begin
            o_feed = (w_k_inc < i_used) ? i_next : '0;
        end
    end

    // request flags
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_type  <= vrta_pkg::REQ_CHECK;
            r_zero  <= 1'b0;
            r_full  <= 1'b0;
            r_found <= 1'b0;
            r_grow  <= 1'b0;
            r_legit <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_ctl.start) begin
            r_type  <= i_req_type;
            r_zero  <= i_req_size == 32'd0;
            r_full  <= i_used == CNT_W'(NUM_REGIONS);
            r_found <= 1'b0;
            r_grow  <= 1'b0;
            r_legit <= 1'b0;
            r_ovf   <= 1'b0;
        end else if (i_ctl.step) begin
            if (w_alloc_slot) begin
                r_grow <= w_fits;
                r_ovf  <= !w_fits;
            end
            if (w_hit) begin
                r_found <= 1'b1;
            end
            if ((r_type == vrta_pkg::REQ_CHECK) && w_in_range) begin
                r_legit <= 1'b1;
            end
        end
    end

    // request operands and captured region
    always_ff @(posedge i_clk) begin
        if (i_ctl.start) begin
            r_addr     <= i_req_address;
            r_len      <= ({1'b0, i_req_size} + PAGE_M1) & PAGE_MASK;
            r_last_end <= '0;
            r_res_addr <= '0;
            r_res_len  <= '0;
        end else if (i_ctl.step) begin
            if ((r_type == vrta_pkg::REQ_ALLOC) && w_is_last) begin
                r_last_end <= w_head_end;
            end
            if (w_alloc_slot && w_fits) begin
                r_res_addr <= r_last_end[31:0];
                r_res_len  <= r_len[31:0];
            end
            if (w_hit) begin
                r_res_addr <= i_head.start_addr;
                r_res_len  <= i_head.byte_len;
            end
        end
    end

    // result summary
    always_comb begin
        o_res.res_addr = r_res_addr;
        o_res.res_len  = r_res_len;
        o_res.legit    = r_legit;
        o_res.grow     = r_grow;
        o_res.shrink   = r_found;
        o_res.status   = vrta_pkg::ST_DONE;
        if ((r_type == vrta_pkg::REQ_ALLOC) && !r_zero && (r_full || r_ovf)) begin
            o_res.status = vrta_pkg::ST_FULL;
        end else if ((r_type == vrta_pkg::REQ_RELEASE) && !r_found) begin
            o_res.status = vrta_pkg::ST_NOT_FOUND;
        end
    end

    a_grow_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_grow |-> (r_type == vrta_pkg::REQ_ALLOC) && !r_ovf)
        else $error("region added by a non-allocate request");

    a_found_rel: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_found |-> (r_type == vrta_pkg::REQ_RELEASE))
        else $error("region removed by a non-release request");

    a_ovf_alloc: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_ovf |-> (r_type == vrta_pkg::REQ_ALLOC) && !r_grow)
        else $error("overrun flagged outside an allocate request");

endmodule

// ----- rtl/core/virtual_region_table_allocator_top.sv -----
// channel   dir  signals                        request
// s         in   i_s_tvalid/o_s_tready          tuser req_type, tdata req_size, req_address
// m         out  o_m_tvalid/i_m_tready          tuser status, tdata result fields
// cfg       in   i_cfg_valid/o_cfg_ready        i_cfg_data pool start address
//
// each request rotates the whole region ring once, then moves the result into the
// output register; a new request is taken only after that result has moved, so
// no new request is taken while a rotation or a result hand-off is in progress.
// reset (synchronous) restores the header entry and clears all other entries.
// a stalled result waits in the output register; the next request is taken
// meanwhile, and its own result waits in the head unit until the register frees.
module virtual_region_table_allocator_top #(
    parameter int NUM_REGIONS = vrta_pkg::NUM_REGIONS_DEF,
    parameter int PAGE_BYTES  = vrta_pkg::PAGE_BYTES_DEF
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_s_tvalid,
    output logic        o_s_tready,
    input  logic [63:0] i_s_tdata,   // req_size [31:0], req_address [63:32]
    input  logic [1:0]  i_s_tuser,   // req_type [1:0]
    output logic        o_m_tvalid,
    input  logic        i_m_tready,
    output logic [71:0] o_m_tdata,   // result_address [31:0], result_length [63:32],
                                     // legitimate [64], zero [71:65]
    output logic [1:0]  o_m_tuser,   // status [1:0]
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [31:0] i_cfg_data
);

    localparam int IDX_W = $clog2(NUM_REGIONS);
    localparam int CNT_W = $clog2(NUM_REGIONS+1);

    localparam logic [1:0] S_IDLE = 2'd0;
    localparam logic [1:0] S_RUN  = 2'd1;
    localparam logic [1:0] S_WAIT = 2'd2;

    logic [1:0]       r_state;
    logic [1:0]       n_state;
    logic [IDX_W-1:0] r_k;
    logic [CNT_W-1:0] r_used;
    logic             r_out_valid;
    logic [71:0]      r_out_data;
    logic [1:0]       r_out_user;

    logic                w_in_acc;
    logic                w_cfg_acc;
    logic                w_step;
    logic                w_out_free;
    logic                w_emit;
    vrta_pkg::t_head_ctl w_ctl;
    vrta_pkg::t_head_res w_res;
    vrta_pkg::t_entry    w_feed;
    vrta_pkg::t_entry    w_q [NUM_REGIONS];
    vrta_pkg::t_entry    w_d [NUM_REGIONS];
    logic [NUM_REGIONS-1:0] w_load;

    // handshakes
    assign o_s_tready  = r_state == S_IDLE;
    assign o_cfg_ready = r_state == S_IDLE;
    assign w_in_acc    = i_s_tvalid && o_s_tready;
    assign w_cfg_acc   = i_cfg_valid && o_cfg_ready;
    assign w_step      = r_state == S_RUN;
    assign w_out_free  = !r_out_valid || i_m_tready;
    assign w_emit      = (r_state == S_WAIT) && w_out_free;

    assign w_ctl.start = w_in_acc;
    assign w_ctl.step  = w_step;

    // region ring: entry k sits at the head on step k
    for (genvar g = 0; g < NUM_REGIONS; g++) begin : g_ring
        if (g == 0) begin : g_first
            always_comb begin
                w_d[g] = w_q[1];
                if (w_cfg_acc) begin
                    w_d[g].start_addr = i_cfg_data;
                    w_d[g].byte_len   = w_q[0].byte_len;
                end
            end
            assign w_load[g] = w_step || w_cfg_acc;
        end else if (g == NUM_REGIONS-1) begin : g_last
            assign w_d[g]    = w_feed;
            assign w_load[g] = w_step;
        end else begin : g_mid
            assign w_d[g]    = w_q[g+1];
            assign w_load[g] = w_step;
        end

        vrta_cell #(
            .RST_START (32'd0),
            .RST_LEN   ((g == 0) ? 32'(PAGE_BYTES) : 32'd0)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_load  (w_load[g]),
            .i_d     (w_d[g]),
            .o_q     (w_q[g])
        );
    end

    vrta_head #(
        .NUM_REGIONS (NUM_REGIONS),
        .PAGE_BYTES  (PAGE_BYTES)
    ) u_head (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_ctl         (w_ctl),
        .i_k           (r_k),
        .i_used        (r_used),
        .i_req_type    (i_s_tuser),
        .i_req_size    (i_s_tdata[31:0]),
        .i_req_address (i_s_tdata[63:32]),
        .i_head        (w_q[0]),
        .i_next        (w_q[1]),
        .o_feed        (w_feed),
        .o_res         (w_res)
    );

    // sequencer
    always_comb begin
        n_state = r_state;
        case (r_state)
            S_IDLE: begin
                if (w_in_acc) n_state = S_RUN;
            end
            S_RUN: begin
                if (r_k == IDX_W'(NUM_REGIONS-1)) n_state = S_WAIT;
            end
            S_WAIT: begin
                if (w_out_free) n_state = S_IDLE;
            end
            default: n_state = S_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
            r_k     <= '0;
            r_used  <= CNT_W'(1);
        end else begin
            r_state <= n_state;
            if (w_in_acc) begin
                r_k <= '0;
            end else if (w_step) begin
                r_k <= r_k + IDX_W'(1);
            end
            if (w_emit && w_res.grow) begin
                r_used <= r_used + CNT_W'(1);
            end else if (w_emit && w_res.shrink) begin
                r_used <= r_used - CNT_W'(1);
            end
        end
    end

    // output register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_emit) begin
            r_out_valid <= 1'b1;
        end else if (i_m_tready) begin
            r_out_valid <= 1'b0;
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_emit) begin
            r_out_data <= {7'd0, w_res.legit, w_res.res_len, w_res.res_addr};
            r_out_user <= w_res.status;
        end
    end

    assign o_m_tvalid = r_out_valid;
    assign o_m_tdata  = r_out_data;
    assign o_m_tuser  = r_out_user;

    a_used_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_used >= CNT_W'(1)) && (r_used <= CNT_W'(NUM_REGIONS)))
        else $error("used entry count out of range");

    a_used_on_emit: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$stable(r_used) |-> $past(r_state) == S_WAIT)
        else $error("used entry count changed outside result hand-off");

    a_run_end: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_state == S_RUN) && (r_k == IDX_W'(NUM_REGIONS-1)) |=> (r_state == S_WAIT))
        else $error("ring rotation did not end after one revolution");

endmodule
